>>> rtl/assert_macros.svh
// Assertion macros shared by the heatmap peak finder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hlpf_pkg.sv
// Shared types and constants for the heatmap local peak finder.
// No dependencies; imported by the window stage and the top level.
package hlpf_pkg;

  // widths fixed by the register map
  localparam int THR_BITS       = 16;
  localparam int WIDTH_REG_BITS = 11;
  localparam int HEIGHT_REG_BITS = 11;
  localparam int CHAN_REG_BITS  = 7;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  // working width for geometry compares, wide enough for any limit
  localparam int GEO_BITS = 13;

  // register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PEAK_THRESHOLD = 2'd0,
    REG_WIDTH_IN_USE   = 2'd1,
    REG_HEIGHT_IN_USE  = 2'd2,
    REG_CHANNEL_COUNT  = 2'd3
  } cfg_reg_t;

  // reset values
  localparam logic signed [THR_BITS-1:0] THRESHOLD_RESET = 16'sd819;
  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET     = 11'd1024;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET    = 11'd1024;
  localparam logic [CHAN_REG_BITS-1:0]   CHANNELS_RESET  = 7'd19;

  // configuration handed to the window stage
  typedef struct packed {
    logic signed [THR_BITS-1:0]  peak_threshold;
    logic [WIDTH_REG_BITS-1:0]   width_in_use;
    logic [HEIGHT_REG_BITS-1:0]  height_in_use;
    logic [CHAN_REG_BITS-1:0]    channel_count;
  } cfg_t;

endpackage

>>> rtl/heatmap_local_peak_finder.sv
// Four-neighbour local peak finder over streamed heatmap channels.
// Throughput one sample per cycle; a peak is queued in the cycle its
// lower-right neighbour is taken; an empty queue offers it the cycle after.
// Two-entry result queue: input stalls in reset or when two peaks wait unread.
// Synchronous reset clears counters, window and queue and restores register
// defaults; line store contents stay as they are and need no clearing pass.
module heatmap_local_peak_finder #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 1024,
  parameter int MAX_CHANNELS = 64,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic [hlpf_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
  input  logic [hlpf_pkg::CFG_DATA_BITS-1:0]           cfg_data,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic signed [SAMPLE_BITS-1:0]                heat_sample,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [$clog2(MAX_WIDTH)-1:0]                 peak_x,
  output logic [$clog2(MAX_HEIGHT)-1:0]                peak_y,
  output logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] peak_channel,
  output logic signed [SAMPLE_BITS-1:0]                peak_score
);
  import hlpf_pkg::*;

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int CB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RES_BITS = XB + YB + CB + SAMPLE_BITS;

  cfg_t cfg;
  logic accept;

  logic [XB-1:0]            ram_raddr, ram_waddr;
  logic                     ram_we;
  logic [2*SAMPLE_BITS-1:0] ram_wdata, ram_q;

  logic                          found;
  logic [XB-1:0]                 found_x;
  logic [YB-1:0]                 found_y;
  logic [CB-1:0]                 found_channel;
  logic signed [SAMPLE_BITS-1:0] found_score;
  logic                          queue_full;
  logic [RES_BITS-1:0]           queue_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_threshold <= THRESHOLD_RESET;
      cfg.width_in_use   <= WIDTH_RESET;
      cfg.height_in_use  <= HEIGHT_RESET;
      cfg.channel_count  <= CHANNELS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PEAK_THRESHOLD: cfg.peak_threshold <= $signed(cfg_data[THR_BITS-1:0]);
        REG_WIDTH_IN_USE:   cfg.width_in_use   <= cfg_data[WIDTH_REG_BITS-1:0];
        REG_HEIGHT_IN_USE:  cfg.height_in_use  <= cfg_data[HEIGHT_REG_BITS-1:0];
        REG_CHANNEL_COUNT:  cfg.channel_count  <= cfg_data[CHAN_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // refuse beats while in reset or while the result queue is full
  assign in_ready = !rst && !queue_full;
  assign accept   = in_valid && in_ready;

  // both line stores share one word: older row high, newer row low
  hlpf_ram #(
    .WIDTH(2 * SAMPLE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  hlpf_window #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_CHANNELS(MAX_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .sample       (heat_sample),
    .ram_q        (ram_q),
    .ram_raddr    (ram_raddr),
    .ram_waddr    (ram_waddr),
    .ram_we       (ram_we),
    .ram_wdata    (ram_wdata),
    .found        (found),
    .found_x      (found_x),
    .found_y      (found_y),
    .found_channel(found_channel),
    .found_score  (found_score)
  );

  hlpf_out_queue #(
    .DATA_BITS(RES_BITS)
  ) u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (found),
    .push_data({found_x, found_y, found_channel, found_score}),
    .full     (queue_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (queue_out)
  );

  // unpack the head result
  assign peak_x       = queue_out[RES_BITS-1 -: XB];
  assign peak_y       = queue_out[YB+CB+SAMPLE_BITS-1 -: YB];
  assign peak_channel = queue_out[CB+SAMPLE_BITS-1 -: CB];
  assign peak_score   = $signed(queue_out[SAMPLE_BITS-1:0]);

endmodule

>>> rtl/hlpf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hlpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/hlpf_window.sv
// Raster counters, cross-shaped tap window and four-neighbour peak test.
// Depends on hlpf_pkg; drives the line store RAM owned by the top level.
module hlpf_window #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 1024,
  parameter int MAX_CHANNELS = 64,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  hlpf_pkg::cfg_t                           cfg,
  input  logic                                     accept,
  input  logic signed [SAMPLE_BITS-1:0]            sample,
  input  logic [2*SAMPLE_BITS-1:0]                 ram_q,
  output logic [$clog2(MAX_WIDTH)-1:0]             ram_raddr,
  output logic [$clog2(MAX_WIDTH)-1:0]             ram_waddr,
  output logic                                     ram_we,
  output logic [2*SAMPLE_BITS-1:0]                 ram_wdata,
  output logic                                     found,
  output logic [$clog2(MAX_WIDTH)-1:0]             found_x,
  output logic [$clog2(MAX_HEIGHT)-1:0]            found_y,
  output logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] found_channel,
  output logic signed [SAMPLE_BITS-1:0]            found_score
);
  import hlpf_pkg::*;

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int CB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  function automatic logic [GEO_BITS-1:0] clamp_geo(
    input logic [GEO_BITS-1:0] v,
    input logic [GEO_BITS-1:0] lo,
    input logic [GEO_BITS-1:0] hi
  );
    logic [GEO_BITS-1:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  logic [XB-1:0] column_counter, column_next;
  logic [YB-1:0] row_counter, row_next;
  logic [CB-1:0] channel_counter, channel_next;

  // middle row taps at c-2, c-1 and upper row tap at c-1, seen from column c
  logic signed [SAMPLE_BITS-1:0] win_ctr, win_right, win_up;
  logic signed [SAMPLE_BITS-1:0] prev_sample;

  logic signed [SAMPLE_BITS-1:0] mid, upper;
  logic [GEO_BITS-1:0] w_eff, h_eff, nch_eff;
  logic [GEO_BITS-1:0] col_inc, row_inc, ch_inc;
  logic                col_wrap, row_wrap, ch_wrap;
  logic                interior, is_peak;

  assign mid   = $signed(ram_q[SAMPLE_BITS-1:0]);
  assign upper = $signed(ram_q[2*SAMPLE_BITS-1:SAMPLE_BITS]);

  // effective geometry
  assign w_eff   = clamp_geo(GEO_BITS'(cfg.width_in_use), GEO_BITS'(3),
                             GEO_BITS'(MAX_WIDTH));
  assign h_eff   = clamp_geo(GEO_BITS'(cfg.height_in_use), GEO_BITS'(3),
                             GEO_BITS'(MAX_HEIGHT));
  assign nch_eff = clamp_geo(GEO_BITS'(cfg.channel_count), GEO_BITS'(1),
                             GEO_BITS'(MAX_CHANNELS));

  // advance raster position
  assign col_inc  = GEO_BITS'(column_counter) + GEO_BITS'(1);
  assign row_inc  = GEO_BITS'(row_counter) + GEO_BITS'(1);
  assign ch_inc   = GEO_BITS'(channel_counter) + GEO_BITS'(1);
  assign col_wrap = (col_inc >= w_eff);
  assign row_wrap = (row_inc >= h_eff);
  assign ch_wrap  = (ch_inc >= nch_eff);

  always_comb begin
    column_next  = column_counter;
    row_next     = row_counter;
    channel_next = channel_counter;
    if (col_wrap) begin
      column_next = '0;
      if (row_wrap) begin
        row_next = '0;
        if (ch_wrap) begin
          channel_next = '0;
        end else begin
          channel_next = ch_inc[CB-1:0];
        end
      end else begin
        row_next = row_inc[YB-1:0];
      end
    end else begin
      column_next = col_inc[XB-1:0];
    end
  end

  // line store access: prefetch the column the next beat will use
  assign ram_raddr = rst ? '0 : (accept ? column_next : column_counter);
  assign ram_waddr = column_counter;
  assign ram_we    = accept;
  assign ram_wdata = {mid, sample};

  // peak test on the pixel one row up and one column left
  assign interior = (GEO_BITS'(column_counter) >= GEO_BITS'(2)) &&
                    (GEO_BITS'(row_counter) >= GEO_BITS'(2));
  assign is_peak  = (win_right > cfg.peak_threshold) && (win_right >= win_up) &&
                    (win_right >= prev_sample) && (win_right >= win_ctr) &&
                    (win_right >= mid);
  // win_right holds the centre before the shift below
  assign found         = accept && interior && is_peak;
  assign found_x       = column_counter - XB'(1);
  assign found_y       = row_counter - YB'(1);
  assign found_channel = channel_counter;
  assign found_score   = win_right;

  // shift window and advance counters on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter  <= '0;
      row_counter     <= '0;
      channel_counter <= '0;
      win_ctr         <= '0;
      win_right       <= '0;
      win_up          <= '0;
    end else if (accept) begin
      column_counter  <= column_next;
      row_counter     <= row_next;
      channel_counter <= channel_next;
      win_ctr         <= win_right;
      win_right       <= mid;
      win_up          <= upper;
    end
  end

  // hold the last sample as the lower neighbour
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_sample <= sample;
    end
  end

endmodule

>>> rtl/hlpf_out_queue.sv
// Two-entry result queue between the peak test and the output channel.
// Depends on assert_macros.svh for its checks.
`include "assert_macros.svh"

module hlpf_out_queue #(
  parameter int DATA_BITS = 42
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_BITS-1:0] out_data
);

  logic [1:0]           count;
  logic [DATA_BITS-1:0] slot_head, slot_tail;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = slot_head;

  // track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // move payload between slots
  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        slot_head <= push_data;
      end else begin
        slot_tail <= push_data;
      end
    end else if (pop && !push) begin
      slot_head <= slot_tail;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        slot_head <= push_data;
      end else begin
        slot_head <= slot_tail;
        slot_tail <= push_data;
      end
    end
  end

  `ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count != 2'd3, "queue count out of range")
  `ASSERT_IMP(a_no_overrun, clk, rst, push, (count != 2'd2) || pop, "push into full queue")
  `ASSERT_NXT(a_pop_drains, clk, rst, pop && !push, count == $past(count) - 2'd1, "pop lost")
  `ASSERT_NXT(a_push_fills, clk, rst, push && !pop, count == $past(count) + 2'd1, "push lost")

endmodule
